// ----- rtl/lsbt_pkg.sv -----
// Shared types and constants for the LIFO stack with binary text pop output.
`default_nettype none

package lsbt_pkg;

  localparam int unsigned Depth     = 64;
  localparam int unsigned ValueBits = 31;
  localparam int unsigned DepthW    = $clog2(Depth + 1);
  localparam int unsigned SerCntW   = $clog2(ValueBits + 1);
  localparam int unsigned CharW     = 6;

  localparam logic [CharW-1:0] CharZero = CharW'(48);
  localparam logic [CharW-1:0] CharOne  = CharW'(49);

  typedef enum logic {
    KindPush = 1'b0,
    KindPop  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    StatusPushOk   = 2'd0,
    StatusPushFull = 2'd1,
    StatusPopEmpty = 2'd2,
    StatusPopChar  = 2'd3
  } status_e;

  typedef enum logic {
    StIdle = 1'b0,
    StSer  = 1'b1
  } state_e;

  typedef struct packed {
    kind_e                kind;
    logic [ValueBits-1:0] value;
  } in_word_t;

  typedef struct packed {
    status_e           status;
    logic [CharW-1:0]  bit_char;
    logic              last;
    logic [DepthW-1:0] depth_now;
  } out_word_t;

  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

  typedef struct packed {
    logic emit;
    logic one;
    logic last;
  } ser_step_t;

endpackage

`default_nettype wire

// ----- rtl/lsbt_cell.sv -----
// One stack entry that shifts down on a push and up on a pop.
`default_nettype none

module lsbt_cell (
  input  logic                          clk_i,
  input  lsbt_pkg::shift_t              ctl_i,
  input  logic [lsbt_pkg::ValueBits-1:0] above_i,
  input  logic [lsbt_pkg::ValueBits-1:0] below_i,
  output logic [lsbt_pkg::ValueBits-1:0] data_o
);
  import lsbt_pkg::*;

  logic [ValueBits-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      data_q <= above_i;
    end else if (ctl_i.pop) begin
      data_q <= below_i;
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ----- rtl/lsbt_serializer.sv -----
// Bit serializer that walks a popped value from its most significant bit.
`default_nettype none

module lsbt_serializer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  logic [lsbt_pkg::ValueBits-1:0] value_i,
  input  logic                           advance_i,
  output lsbt_pkg::ser_step_t            step_o
);
  import lsbt_pkg::*;

  logic [ValueBits-1:0] sh_q, sh_d;
  logic [SerCntW-1:0]   cnt_q, cnt_d;
  logic                 seen_q, seen_d;
  logic                 bit_cur;

  assign bit_cur     = sh_q[ValueBits-1];
  assign step_o.one  = bit_cur;
  assign step_o.last = (cnt_q == SerCntW'(1));
  assign step_o.emit = seen_q | bit_cur | step_o.last;

  always_comb begin
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    seen_d = seen_q;
    if (load_i) begin
      sh_d   = value_i;
      cnt_d  = SerCntW'(ValueBits);
      seen_d = 1'b0;
    end else if (advance_i && (cnt_q != '0)) begin
      sh_d   = sh_q << 1;
      cnt_d  = cnt_q - SerCntW'(1);
      seen_d = seen_q | bit_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      seen_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      seen_q <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

endmodule

`default_nettype wire

// ----- rtl/lifo_stack_binary_text_pop_unit.sv -----
// Top level of the LIFO stack whose pops are sent out as binary text.
//
//   Channel | Direction | Handshake         | Word
//   in      | input     | in_valid_i/stall  | lsbt_pkg::in_word_t
//   out     | output    | out_valid_o/stall | lsbt_pkg::out_word_t
//
// A push produces one word. A pop walks the serializer one bit per cycle
// unless the output stalls, giving a word per significant digit, or
// one for a zero value; an empty pop produces one word.
// The stack is a row of cells that all shift together on push and pop.
// Reset empties the stack; the cell contents are not cleared.
// A stall on the output holds the serializer until the word is taken.
`default_nettype none

module lifo_stack_binary_text_pop_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lsbt_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lsbt_pkg::out_word_t out_data_o
);
  import lsbt_pkg::*;

  localparam logic [DepthW-1:0] DepthFull = DepthW'(Depth);

  state_e              state_q, state_d;
  logic [DepthW-1:0]   count_q, count_d;
  logic                out_valid_q, out_valid_d;
  out_word_t           out_q, out_d;
  logic                in_accept;
  logic                advance;
  logic                ser_load;
  logic                full;
  logic                empty;
  shift_t              shift_ctl;
  ser_step_t           ser_step;
  logic [ValueBits-1:0] cell_data [Depth];

  assign full       = (count_q == DepthFull);
  assign empty      = (count_q == '0);
  assign in_stall_o = (state_q != StIdle) || (out_valid_q && out_stall_i);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign advance    = (state_q == StSer) && (!out_valid_q || !out_stall_i);
  assign ser_load   = in_accept && (in_data_i.kind == KindPop) && !empty;

  assign shift_ctl.push = in_accept && (in_data_i.kind == KindPush) && !full;
  assign shift_ctl.pop  = ser_load;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic [ValueBits-1:0] above;
    logic [ValueBits-1:0] below;
    if (i == 0) begin : g_top
      assign above = in_data_i.value;
    end else begin : g_mid
      assign above = cell_data[i-1];
    end
    if (i == Depth - 1) begin : g_bottom
      assign below = '0;
    end else begin : g_up
      assign below = cell_data[i+1];
    end
    lsbt_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (shift_ctl),
      .above_i (above),
      .below_i (below),
      .data_o  (cell_data[i])
    );
  end

  lsbt_serializer u_ser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (ser_load),
    .value_i   (cell_data[0]),
    .advance_i (advance),
    .step_o    (ser_step)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          out_valid_d    = 1'b1;
          out_d.bit_char = '0;
          out_d.last     = 1'b1;
          if (in_data_i.kind == KindPush) begin
            if (full) begin
              out_d.status    = StatusPushFull;
              out_d.depth_now = count_q;
            end else begin
              count_d         = count_q + DepthW'(1);
              out_d.status    = StatusPushOk;
              out_d.depth_now = count_d;
            end
          end else if (empty) begin
            out_d.status    = StatusPopEmpty;
            out_d.depth_now = '0;
          end else begin
            out_valid_d = out_valid_q && out_stall_i;
            count_d     = count_q - DepthW'(1);
            state_d     = StSer;
          end
        end
      end
      StSer: begin
        if (advance) begin
          if (ser_step.emit) begin
            out_valid_d     = 1'b1;
            out_d.status    = StatusPopChar;
            out_d.bit_char  = ser_step.one ? CharOne : CharZero;
            out_d.last      = ser_step.last;
            out_d.depth_now = count_q;
          end
          if (ser_step.last) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthFull)
    else $error("stack count exceeds capacity");

  a_pop_enters_ser: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ser_load |=> (state_q == StSer))
    else $error("pop of a held value did not start the serializer");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift_ctl.push |=> (count_q == $past(count_q) + DepthW'(1)))
    else $error("push did not grow the stack");

  a_non_char_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.status != StatusPopChar)) |-> out_q.last)
    else $error("push or empty-pop word without last");

  a_ser_full_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && ser_step.last) |=> (state_q == StIdle))
    else $error("serializer did not return to idle after its last bit");

endmodule

`default_nettype wire

// ----- test/lifo_stack_binary_text_pop_unit_tb.sv -----
// Self-checking testbench for the LIFO stack that pops its values as binary text.
module lifo_stack_binary_text_pop_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lsbt_pkg::*;

  localparam int HoldCycles = 300;
  localparam int IdleLimit  = 3000;
  localparam int TailCycles = 2 * ValueBits;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_data_o;

  lifo_stack_binary_text_pop_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  logic [ValueBits-1:0] held [Depth];
  int                   held_cnt;
  out_word_t            due_words [$];

  bit calm;
  int hold_asked;
  int hold_done;
  int fail_cnt;
  int n_push;
  int n_full;
  int n_pop;
  int n_empty;
  int n_words;
  int idle_cycles;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) begin
      return $urandom_range(1, 2);
    end else if (r < 90) begin
      return $urandom_range(3, 6);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [ValueBits-1:0] rand_value();
    int r;
    int len;
    r = $urandom_range(9);
    if (r == 0) begin
      return '0;
    end else if (r == 1) begin
      return '1;
    end
    len = $urandom_range(1, ValueBits);
    return (ValueBits'($urandom) & ((ValueBits'(1) << len) - ValueBits'(1))) |
           (ValueBits'(1) << (len - 1));
  endfunction

  // Works out the words that one accepted input word must produce.
  function automatic void predict_stack_op(in_word_t w);
    out_word_t            r;
    logic [ValueBits-1:0] v;
    int                   len;
    r      = '0;
    r.last = 1'b1;
    if (w.kind == KindPush) begin
      n_push++;
      if (held_cnt >= Depth) begin
        n_full++;
        r.status = StatusPushFull;
      end else begin
        held[held_cnt] = w.value;
        held_cnt++;
        r.status = StatusPushOk;
      end
      r.depth_now = DepthW'(held_cnt);
      due_words.push_back(r);
    end else if (held_cnt == 0) begin
      n_pop++;
      n_empty++;
      r.status = StatusPopEmpty;
      due_words.push_back(r);
    end else begin
      n_pop++;
      held_cnt--;
      v   = held[held_cnt];
      len = 0;
      for (int i = 0; i < ValueBits; i++) begin
        if (v[i]) len = i + 1;
      end
      r.status    = StatusPopChar;
      r.depth_now = DepthW'(held_cnt);
      if (len == 0) begin
        r.bit_char = CharZero;
        due_words.push_back(r);
      end else begin
        for (int k = len - 1; k >= 0; k--) begin
          r.bit_char = v[k] ? CharOne : CharZero;
          r.last     = (k == 0);
          due_words.push_back(r);
        end
      end
    end
  endfunction

  // Valid stays high after acceptance so that a back-to-back word needs one assignment only.
  task automatic send_word(input kind_e k, input logic [ValueBits-1:0] v);
    in_word_t w;
    int       gap;
    w.kind  = k;
    w.value = v;
    gap     = (calm || $urandom_range(2) != 0) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    predict_stack_op(w);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (due_words.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  task automatic test_directed();
    calm = 1'b0;
    send_word(KindPop, '0);
    send_word(KindPush, '0);
    send_word(KindPop, '1);
    send_word(KindPush, '1);
    send_word(KindPush, ValueBits'(1));
    send_word(KindPush, ValueBits'(2));
    send_word(KindPop, '0);
    send_word(KindPop, '0);
    send_word(KindPop, '0);
    send_word(KindPush, ValueBits'(32'h2AAA_AAAA));
    send_word(KindPush, ValueBits'(32'h5555_5555));
    send_word(KindPush, ValueBits'(32'h4000_0000));
    send_word(KindPush, '0);
    send_word(KindPop, '0);
    send_word(KindPop, '0);
    send_word(KindPop, '0);
    send_word(KindPop, '0);
    send_word(KindPop, '1);
    drain();
  endtask

  task automatic test_fill_and_overflow();
    calm = 1'b1;
    while (held_cnt < Depth) send_word(KindPush, rand_value());
    calm = 1'b0;
    send_word(KindPush, '1);
    send_word(KindPush, '0);
    send_word(KindPop, '0);
    send_word(KindPush, '1);
    send_word(KindPush, rand_value());
    while (held_cnt > 0) send_word(KindPop, rand_value());
    send_word(KindPop, '1);
    drain();
  endtask

  task automatic test_random_mix();
    int bias;
    for (int chunk = 0; chunk < 5; chunk++) begin
      calm = ($urandom_range(3) == 0);
      case ($urandom_range(3))
        0: begin
          bias = 20;
        end
        1: begin
          bias = 50;
        end
        2: begin
          bias = 80;
        end
        default: begin
          bias = 95;
        end
      endcase
      repeat (38) begin
        if ($urandom_range(99) < bias) begin
          send_word(KindPush, rand_value());
        end else begin
          send_word(KindPop, rand_value());
        end
      end
    end
    drain();
  endtask

  task automatic test_output_hold();
    calm = 1'b1;
    hold_asked++;
    repeat (12) send_word(KindPush, rand_value());
    repeat (6) send_word(KindPop, '0);
    calm = 1'b0;
    repeat (8) send_word(KindPop, '0);
    drain();
  endtask

  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    held_cnt   = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_fill_and_overflow();
    test_output_hold();
    test_random_mix();
    $display("Run covered %0d pushes (%0d refused as full) and %0d pops (%0d on empty).",
             n_push, n_full, n_pop, n_empty);
    $display("%0d output words were checked against the predicted stack.", n_words);
    if (fail_cnt == 0) begin
      $display("lifo_stack_binary_text_pop_unit_tb passed");
    end else begin
      $display("lifo_stack_binary_text_pop_unit_tb failed");
    end
    $finish;
  end

  initial begin
    int stall_left;
    stall_left  = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_asked != hold_done) begin
        hold_done  = hold_asked;
        stall_left = HoldCycles;
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else if (calm || $urandom_range(3) != 0) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b1;
        stall_left = pick_gap() - 1;
      end
    end
  end

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_words++;
      if (due_words.size() == 0) begin
        $error("unexpected word: status %0d bit_char %0d last %0d depth_now %0d",
               out_data_o.status, out_data_o.bit_char, out_data_o.last, out_data_o.depth_now);
        fail_cnt++;
      end else begin
        want = due_words.pop_front();
        if (out_data_o.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_data_o.status);
          fail_cnt++;
        end
        if (out_data_o.bit_char !== want.bit_char) begin
          $error("bit_char: expected %0d, actual %0d", want.bit_char, out_data_o.bit_char);
          fail_cnt++;
        end
        if (out_data_o.last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, out_data_o.last);
          fail_cnt++;
        end
        if (out_data_o.depth_now !== want.depth_now) begin
          $error("depth_now: expected %0d, actual %0d", want.depth_now, out_data_o.depth_now);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout with %0d words still expected.", due_words.size());
        $display("lifo_stack_binary_text_pop_unit_tb failed");
        $finish;
      end
    end
  end

endmodule
